// ----- rtl/linear_probe_index_map_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for linear_probe_index_map_unit
// Clocked, reset-gated property wrappers shared by the RTL checks.
// ---------------------------------------------------------------------------
`ifndef LINEAR_PROBE_INDEX_MAP_UNIT_ASSERT_SVH
`define LINEAR_PROBE_INDEX_MAP_UNIT_ASSERT_SVH

// same-cycle implication
`define LPIM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPIM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lpim_pkg.sv -----
// ---------------------------------------------------------------------------
// lpim_pkg
// Widths, command and status codes, and FSM type for the index map.
// ---------------------------------------------------------------------------
`default_nettype none

package lpim_pkg;

  localparam int KEY_W   = 32;
  localparam int SLOT_W  = 12;
  localparam int CNT_W   = 13;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 3;
  localparam int ENT_W   = SLOT_W + KEY_W;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam int DEF_TABLE_ENTRIES = 4096;
  localparam int DEF_SLOT_COUNT    = 4096;

  localparam logic [CNT_W-1:0] CAP_RESET = 13'd4096;

  // register select is paddr[2]
  localparam logic REG_CAP_LIMIT = 1'b0;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_FOUND     = 3'd0;
  localparam logic [STAT_W-1:0] STAT_ADDED     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] STAT_PRESENT   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_CAP_FULL  = 3'd4;
  localparam logic [STAT_W-1:0] STAT_INVALID   = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_CLEAR
  } lpim_state_t;

endpackage

`default_nettype wire

// ----- rtl/lpim_ram.sv -----
// ---------------------------------------------------------------------------
// lpim_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module lpim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/lpim_hash.sv -----
// ---------------------------------------------------------------------------
// lpim_hash
// Home index of a key: key mod TABLE_ENTRIES. Mask for a power of two,
// otherwise a reciprocal multiply and a subtract, each registered.
// ---------------------------------------------------------------------------
`default_nettype none

module lpim_hash #(
  parameter int TABLE_ENTRIES = lpim_pkg::DEF_TABLE_ENTRIES
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [lpim_pkg::KEY_W-1:0]       key,
  output logic                                  done,
  output logic [$clog2(TABLE_ENTRIES)-1:0]      rem
);

  import lpim_pkg::*;

  localparam int  IDX_W = $clog2(TABLE_ENTRIES);
  localparam bit  POW2  = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

  logic             done_r;
  logic [IDX_W-1:0] rem_r;

  generate
    if (POW2) begin : g_mask
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
        if (start) begin
          rem_r <= key[IDX_W-1:0];
        end
      end
    end else begin : g_div
      // quotient = key * ceil(2^SH / N) >> SH, exact for every 32-bit key;
      // the remainder is below N, so its low IDX_W bits are all we need
      localparam int          SH         = KEY_W + IDX_W;
      localparam logic [64:0] RECIP_FULL = ((65'd1 << SH) + 65'(TABLE_ENTRIES) - 65'd1)
                                           / 65'(TABLE_ENTRIES);
      localparam logic [32:0] RECIP      = RECIP_FULL[32:0];
      localparam logic [IDX_W-1:0] DIV_LO = IDX_W'(TABLE_ENTRIES);

      logic             run_r;
      logic [IDX_W-1:0] quo_r;
      logic [IDX_W-1:0] key_lo_r;
      logic [64:0]      prod;

      assign prod = 65'(key) * 65'(RECIP);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          run_r  <= 1'b0;
          done_r <= 1'b0;
        end else begin
          run_r  <= start;
          done_r <= run_r;
        end
        if (start) begin
          quo_r    <= prod[SH +: IDX_W];
          key_lo_r <= key[IDX_W-1:0];
        end
        if (run_r) begin
          rem_r <= key_lo_r - quo_r * DIV_LO;
        end
      end
    end
  endgenerate

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ----- rtl/lpim_engine.sv -----
// ---------------------------------------------------------------------------
// lpim_engine
// Request sequencer: clear sweep, linear probe over the entry RAM with one
// read issued per cycle, and the insert write-back.
// ---------------------------------------------------------------------------
`default_nettype none

module lpim_engine #(
  parameter int TABLE_ENTRIES = lpim_pkg::DEF_TABLE_ENTRIES,
  parameter int SLOT_COUNT    = lpim_pkg::DEF_SLOT_COUNT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  input  wire logic [lpim_pkg::CMD_W-1:0]            in_cmd,
  input  wire logic [lpim_pkg::KEY_W-1:0]            in_key,
  output logic                                       busy,
  input  wire logic [lpim_pkg::CNT_W-1:0]            cap_limit,
  output logic                                       hash_start,
  input  wire logic                                  hash_done,
  input  wire logic [$clog2(TABLE_ENTRIES)-1:0]      hash_rem,
  output logic                                       ram_we,
  output logic [$clog2(TABLE_ENTRIES)-1:0]           ram_waddr,
  output logic [lpim_pkg::ENT_W-1:0]                 ram_wdata,
  output logic [$clog2(TABLE_ENTRIES)-1:0]           ram_raddr,
  input  wire logic [lpim_pkg::ENT_W-1:0]            ram_rdata,
  output logic                                       out_valid,
  output logic [lpim_pkg::STAT_W-1:0]                out_status,
  output logic [lpim_pkg::SLOT_W-1:0]                out_slot
);

  import lpim_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [16:0]      SLOT_LIM  = 17'(SLOT_COUNT);

  lpim_state_t       state_r, state_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic              ins_r, ins_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  vis_r, vis_nxt;
  logic [CNT_W-1:0]  alloc_r, alloc_nxt;
  logic              clr_resp_r, clr_resp_nxt;
  logic              res_valid_r, res_valid_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;

  logic              accept;
  logic              probe_go;
  logic [KEY_W-1:0]  q_key;
  logic [SLOT_W-1:0] q_slot;
  logic              hit, empty, last_visit;
  logic [IDX_W-1:0]  idx_inc;
  logic [16:0]       lim;
  logic              can_alloc;
  logic              ins_write;

  assign accept = start && !busy;
  assign q_key  = ram_rdata[KEY_W-1:0];
  assign q_slot = ram_rdata[ENT_W-1:KEY_W];
  assign hit    = (q_key == key_r);
  assign empty  = (q_key == '0);
  assign last_visit = (vis_r == LAST_IDX);
  assign idx_inc = (idx_r == LAST_IDX) ? '0 : idx_r + IDX_W'(1);
  assign lim = (17'(cap_limit) > SLOT_LIM) ? SLOT_LIM : 17'(cap_limit);
  assign can_alloc = 17'(alloc_r) < lim;
  assign ins_write = (state_r == S_PROBE) && !hit && empty && ins_r && can_alloc;

  always_comb begin
    unique case (in_cmd)
      CMD_LOOKUP, CMD_INSERT: probe_go = (in_key != '0);
      default:                probe_go = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_cmd == CMD_CLEAR) begin
          state_nxt = S_CLEAR;
        end else if (accept && probe_go) begin
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (hit || empty || last_visit) begin
          state_nxt = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    busy       = (state_r != S_IDLE);
    hash_start = accept && probe_go;
    ram_we     = (state_r == S_CLEAR) || ins_write;
    ram_waddr  = idx_r;
    ram_wdata  = (state_r == S_CLEAR) ? '0 : {alloc_r[SLOT_W-1:0], key_r};
    unique case (state_r)
      S_HASH:  ram_raddr = hash_rem;
      S_PROBE: ram_raddr = idx_inc;   // prefetch the next entry
      default: ram_raddr = idx_r;
    endcase
  end

  // datapath
  always_comb begin
    key_nxt        = key_r;
    ins_nxt        = ins_r;
    idx_nxt        = idx_r;
    vis_nxt        = vis_r;
    alloc_nxt      = alloc_r;
    clr_resp_nxt   = clr_resp_r;
    res_valid_nxt  = 1'b0;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt = in_key;
          ins_nxt = (in_cmd == CMD_INSERT);
          idx_nxt = '0;
          vis_nxt = '0;
          if (in_cmd == CMD_CLEAR) begin
            clr_resp_nxt = 1'b1;
          end else if (!probe_go) begin
            res_valid_nxt  = 1'b1;
            res_status_nxt = STAT_INVALID;
            res_slot_nxt   = '0;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          idx_nxt = hash_rem;
        end
      end
      S_PROBE: begin
        idx_nxt = idx_inc;
        vis_nxt = vis_r + IDX_W'(1);
        if (hit) begin
          res_valid_nxt  = 1'b1;
          res_status_nxt = ins_r ? STAT_PRESENT : STAT_FOUND;
          res_slot_nxt   = ins_r ? '0 : q_slot;
        end else if (empty) begin
          res_valid_nxt = 1'b1;
          res_slot_nxt  = '0;
          if (!ins_r) begin
            res_status_nxt = STAT_NOT_FOUND;
          end else if (can_alloc) begin
            res_status_nxt = STAT_ADDED;
            res_slot_nxt   = alloc_r[SLOT_W-1:0];
            alloc_nxt      = alloc_r + CNT_W'(1);
          end else begin
            res_status_nxt = STAT_CAP_FULL;
          end
        end else if (last_visit) begin
          // wrapped all the way round: no key, no hole
          res_valid_nxt  = 1'b1;
          res_status_nxt = STAT_INVALID;
          res_slot_nxt   = '0;
        end
      end
      S_CLEAR: begin
        idx_nxt = idx_inc;
        if (idx_r == LAST_IDX) begin
          alloc_nxt    = '0;
          clr_resp_nxt = 1'b0;
          if (clr_resp_r) begin
            res_valid_nxt  = 1'b1;
            res_status_nxt = STAT_FOUND;
            res_slot_nxt   = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;   // clearing pass after reset
      idx_r       <= '0;
      alloc_r     <= '0;
      clr_resp_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      alloc_r     <= alloc_nxt;
      clr_resp_r  <= clr_resp_nxt;
      res_valid_r <= res_valid_nxt;
    end
    key_r        <= key_nxt;
    ins_r        <= ins_nxt;
    vis_r        <= vis_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
  end

  assign out_valid  = res_valid_r;
  assign out_status = res_status_r;
  assign out_slot   = res_slot_r;

endmodule

`default_nettype wire

// ----- rtl/linear_probe_index_map_unit.sv -----
// ---------------------------------------------------------------------------
// linear_probe_index_map_unit
// Open-addressed key-to-slot map, key mod TABLE_ENTRIES hash, linear probing with wrap.
// ---------------------------------------------------------------------------
//  Channel   Ports                               Handshake
//  request   start, in_cmd, in_key               taken when start && !busy
//  result    out_valid, out_status, out_slot     one-cycle strobe, no stall
//  config    psel/penable/pwrite/paddr/pwdata    APB, pready tied high
//
//  Lookup/insert: a registered hash step (mask, or multiply then subtract
//  if TABLE_ENTRIES is not a power of two), then one read per probed entry
//  (single read port of the entry RAM); the result shows the cycle after the
//  last probe, when busy is already low. Clear: every entry, one written per cycle.
//  After reset a clearing pass over all TABLE_ENTRIES entries holds busy high.
//  The result strobe cannot be held off by the receiver.
// ---------------------------------------------------------------------------
`default_nettype none

module linear_probe_index_map_unit #(
  parameter int TABLE_ENTRIES = lpim_pkg::DEF_TABLE_ENTRIES,
  parameter int SLOT_COUNT    = lpim_pkg::DEF_SLOT_COUNT
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [lpim_pkg::CMD_W-1:0]      in_cmd,
  input  wire logic [lpim_pkg::KEY_W-1:0]      in_key,
  output logic                                 out_valid,
  output logic [lpim_pkg::STAT_W-1:0]          out_status,
  output logic [lpim_pkg::SLOT_W-1:0]          out_slot,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lpim_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [lpim_pkg::PDATA_W-1:0]    pwdata,
  output logic [lpim_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready
);

  import lpim_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  logic [CNT_W-1:0] cap_r, cap_nxt;
  logic             cfg_wr;

  logic             hash_start, hash_done;
  logic [IDX_W-1:0] hash_rem;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;

  logic             added_res, inval_res, bad_key_req;

  // config register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAP_LIMIT);
  assign cap_nxt = cfg_wr ? pwdata[CNT_W-1:0] : cap_r;
  assign prdata = (paddr[2] == REG_CAP_LIMIT) ? PDATA_W'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  lpim_hash #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (in_key),
    .done  (hash_done),
    .rem   (hash_rem)
  );

  lpim_ram #(
    .WIDTH(ENT_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lpim_engine #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .SLOT_COUNT   (SLOT_COUNT)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_cmd     (in_cmd),
    .in_key     (in_key),
    .busy       (busy),
    .cap_limit  (cap_r),
    .hash_start (hash_start),
    .hash_done  (hash_done),
    .hash_rem   (hash_rem),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_slot   (out_slot)
  );

  assign added_res   = out_valid && (out_status == STAT_ADDED);
  assign inval_res   = out_valid && (out_status == STAT_INVALID);
  assign bad_key_req = start && !busy && (in_key == '0) && (in_cmd != CMD_CLEAR);

`include "linear_probe_index_map_unit_assert.svh"

  `LPIM_ASSERT_NOW(a_result_when_idle, out_valid, !busy, "result while busy")
  `LPIM_ASSERT_NOW(a_write_only_busy, ram_we, busy, "entry write while idle")
  `LPIM_ASSERT_NOW(a_added_wrote, added_res, $past(ram_we), "added without write")
  `LPIM_ASSERT_NEXT(a_zero_key, bad_key_req, inval_res, "zero key not rejected")

endmodule

`default_nettype wire
